/* rtl/first_fit_segment_allocator_macros.svh */
// Assertion macros shared by the allocator checker
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define FFSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication, disabled while reset is asserted
`define FFSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

/* rtl/ffsa_pkg.sv */
// Types, constants and codes shared by the segment allocator modules
package ffsa_pkg;

  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned SEG_IDX_W    = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W        = SEG_IDX_W + 1;
  localparam int unsigned ADDR_W       = 24;
  localparam int unsigned LEN_W        = ADDR_W + 1;
  localparam int unsigned EXT_W        = LEN_W + 1;
  localparam int unsigned AL_W         = 5;
  localparam int unsigned PAD_W        = 32;
  localparam int unsigned ENTRY_W      = ADDR_W + LEN_W;
  localparam logic [LEN_W-1:0] SPACE_SIZE = LEN_W'(1) << ADDR_W;

  typedef enum logic [1:0] {
    OP_ALLOC_FIRST = 2'd0,
    OP_ALLOC_LAST  = 2'd1,
    OP_FREE        = 2'd2,
    OP_QUERY       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADLEN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_WR1, S_SHF_RD, S_SHF_WR, S_INS, S_DONE
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_SCAN_RD, CMD_SCAN_EV, CMD_DECIDE, CMD_WR1,
    CMD_SHF_RD, CMD_SHF_WR, CMD_INS, CMD_DONE
  } cmd_e;

  typedef struct packed {
    logic bad;
    logic scan_end;
    logic hit;
    logic ok;
    logic shift;
    logic shf_end;
  } dp_status_t;

endpackage

/* rtl/ffsa_ram.sv */
// Generic single-write, single-read RAM with registered read data
module ffsa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ffsa_ctrl.sv */
// Sequencer that steps the allocator datapath through scan, update and shift
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t stat_i,
  output cmd_e       cmd_o,
  output logic       busy_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        if (stat_i.bad) begin
          state_d = S_DONE;
        end else if (stat_i.scan_end) begin
          state_d = S_DECIDE;
        end else begin
          cmd_o   = CMD_SCAN_RD;
          state_d = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        cmd_o   = CMD_SCAN_EV;
        state_d = stat_i.hit ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        cmd_o   = CMD_DECIDE;
        state_d = S_WR1;
      end
      S_WR1: begin
        if (!stat_i.ok) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_WR1;
          state_d = S_SHF_RD;
        end
      end
      S_SHF_RD: begin
        if (!stat_i.shift || stat_i.shf_end) begin
          state_d = S_INS;
        end else begin
          cmd_o   = CMD_SHF_RD;
          state_d = S_SHF_WR;
        end
      end
      S_SHF_WR: begin
        cmd_o   = CMD_SHF_WR;
        state_d = S_SHF_RD;
      end
      S_INS: begin
        cmd_o   = CMD_INS;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o   = CMD_DONE;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* rtl/ffsa_dp.sv */
// Segment table, scan evaluation, update planning and result registers
module ffsa_dp import ffsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                cmd_i,
  output dp_status_t          stat_o,
  input  logic [1:0]          operation_i,
  input  logic [LEN_W-1:0]    length_i,
  input  logic [AL_W-1:0]     align_log2_i,
  input  logic [ADDR_W-1:0]   release_address_i,
  output logic                result_valid_o,
  output logic [1:0]          status_o,
  output logic [ADDR_W-1:0]   granted_address_o,
  output logic [LEN_W-1:0]    total_free_o
);

  op_e                op_q;
  logic [LEN_W-1:0]   len_q;
  logic [AL_W-1:0]    al_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [CNT_W-1:0]   cnt_q, idx_q, k_q, sp_q, lim_q, w1_idx_q, ins_idx_q;
  logic [LEN_W-1:0]   sum_q, pl_q, hl_q;
  logic [ADDR_W-1:0]  pb_q, hb_q, grant_q;
  logic [PAD_W-1:0]   pad_q;
  status_e            stat_q;
  logic               bad_q, hit_q, wr1_q, shift_q, dn_q, ins_q, inc_q, dec_q;
  logic [ENTRY_W-1:0] w1_data_q, ins_data_q;
  logic               res_vld_q;
  logic [1:0]         res_st_q;
  logic [ADDR_W-1:0]  res_grant_q;
  logic [LEN_W-1:0]   res_total_q;

  logic [ENTRY_W-1:0]   rd_data;
  logic [ADDR_W-1:0]    rd_base;
  logic [LEN_W-1:0]     rd_len;
  logic                 is_alloc, from_top, full, ev_hit, fits;
  logic [CNT_W-1:0]     scan_addr, sp_nxt;
  logic [PAD_W-1:0]     mask, pad_c;
  logic [LEN_W-1:0]     leftover;
  logic [ADDR_W-1:0]    place;
  logic [EXT_W-1:0]     fend, pend, in_end;
  logic                 in_len_bad;
  logic                 we, re;
  logic [SEG_IDX_W-1:0] waddr, raddr;
  logic [ENTRY_W-1:0]   wdata;

  assign rd_base  = rd_data[ENTRY_W-1:LEN_W];
  assign rd_len   = rd_data[LEN_W-1:0];
  assign is_alloc = (op_q == OP_ALLOC_FIRST) || (op_q == OP_ALLOC_LAST);
  assign from_top = (op_q == OP_ALLOC_LAST);
  assign full     = (cnt_q >= CNT_W'(MAX_SEGMENTS));

  assign scan_addr = from_top ? CNT_W'(cnt_q - idx_q - CNT_W'(1)) : idx_q;
  assign mask      = (PAD_W'(1) << al_q) - PAD_W'(1);
  assign pad_c     = (PAD_W'(0) - PAD_W'(rd_base)) & mask;
  assign fits      = ((PAD_W + 1)'(pad_c) + (PAD_W + 1)'(len_q)) <= (PAD_W + 1)'(rd_len);
  assign ev_hit    = is_alloc ? fits : ((op_q == OP_FREE) && (rd_base >= addr_q));

  assign leftover = LEN_W'(hl_q - len_q - LEN_W'(pad_q));
  assign place    = ADDR_W'(hb_q + pad_q[ADDR_W-1:0]);
  assign fend     = EXT_W'(addr_q) + EXT_W'(len_q);
  assign pend     = EXT_W'(pb_q) + EXT_W'(pl_q);

  assign in_end     = EXT_W'(release_address_i) + EXT_W'(length_i);
  assign in_len_bad = (length_i == '0) || (length_i > SPACE_SIZE);

  assign sp_nxt = dn_q ? CNT_W'(sp_q + CNT_W'(1)) : CNT_W'(sp_q - CNT_W'(1));

  assign stat_o.bad      = bad_q;
  assign stat_o.scan_end = (idx_q >= cnt_q);
  assign stat_o.hit      = ev_hit;
  assign stat_o.ok       = (stat_q == ST_OK);
  assign stat_o.shift    = shift_q;
  assign stat_o.shf_end  = dn_q ? (CNT_W'(sp_q + CNT_W'(1)) >= cnt_q) : (sp_q <= lim_q);

  always_comb begin
    we    = 1'b0;
    waddr = w1_idx_q[SEG_IDX_W-1:0];
    wdata = w1_data_q;
    unique case (cmd_i)
      CMD_WR1: begin
        we = wr1_q;
      end
      CMD_SHF_WR: begin
        we    = 1'b1;
        waddr = sp_q[SEG_IDX_W-1:0];
        wdata = rd_data;
      end
      CMD_INS: begin
        we    = ins_q;
        waddr = ins_idx_q[SEG_IDX_W-1:0];
        wdata = ins_data_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign re    = (cmd_i == CMD_SCAN_RD) || (cmd_i == CMD_SHF_RD);
  assign raddr = (cmd_i == CMD_SHF_RD) ? sp_nxt[SEG_IDX_W-1:0] : scan_addr[SEG_IDX_W-1:0];

  ffsa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= (cmd_i == CMD_DONE);
      if (cmd_i == CMD_DONE && stat_q == ST_OK) begin
        if (inc_q) begin
          cnt_q <= CNT_W'(cnt_q + CNT_W'(1));
        end else if (dec_q) begin
          cnt_q <= CNT_W'(cnt_q - CNT_W'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q    <= op_e'(operation_i);
        len_q   <= length_i;
        al_q    <= align_log2_i;
        addr_q  <= release_address_i;
        idx_q   <= '0;
        sum_q   <= '0;
        hit_q   <= 1'b0;
        wr1_q   <= 1'b0;
        shift_q <= 1'b0;
        ins_q   <= 1'b0;
        inc_q   <= 1'b0;
        dec_q   <= 1'b0;
        bad_q   <= 1'b0;
        stat_q  <= ST_OK;
        if (operation_i != OP_QUERY) begin
          if (in_len_bad || (operation_i == OP_FREE && in_end > EXT_W'(SPACE_SIZE))) begin
            bad_q  <= 1'b1;
            stat_q <= ST_BADLEN;
          end
        end
      end
      CMD_SCAN_EV: begin
        if (ev_hit) begin
          hit_q <= 1'b1;
          k_q   <= scan_addr;
          hb_q  <= rd_base;
          hl_q  <= rd_len;
          pad_q <= pad_c;
        end else begin
          idx_q <= CNT_W'(idx_q + CNT_W'(1));
          pb_q  <= rd_base;
          pl_q  <= rd_len;
          sum_q <= LEN_W'(sum_q + rd_len);
        end
      end
      CMD_DECIDE: begin
        grant_q <= place;
        if (is_alloc) begin
          if (!hit_q) begin
            stat_q <= ST_NOFIT;
          end else if (pad_q == '0) begin
            if (leftover != '0) begin
              wr1_q     <= 1'b1;
              w1_idx_q  <= k_q;
              w1_data_q <= {ADDR_W'(hb_q + len_q[ADDR_W-1:0]), leftover};
            end else begin
              shift_q <= 1'b1;
              dn_q    <= 1'b1;
              sp_q    <= k_q;
              dec_q   <= 1'b1;
            end
          end else if (leftover != '0 && full) begin
            stat_q <= ST_FULL;
          end else begin
            wr1_q     <= 1'b1;
            w1_idx_q  <= k_q;
            w1_data_q <= {hb_q, LEN_W'(pad_q)};
            if (leftover != '0) begin
              shift_q    <= 1'b1;
              dn_q       <= 1'b0;
              sp_q       <= cnt_q;
              lim_q      <= CNT_W'(k_q + CNT_W'(1));
              ins_q      <= 1'b1;
              ins_idx_q  <= CNT_W'(k_q + CNT_W'(1));
              ins_data_q <= {ADDR_W'(place + len_q[ADDR_W-1:0]), leftover};
              inc_q      <= 1'b1;
            end
          end
        end else if (op_q == OP_FREE) begin
          if ((hit_q && fend > EXT_W'(hb_q)) || (idx_q != '0 && pend > EXT_W'(addr_q))) begin
            stat_q <= ST_BADLEN;
          end else if (hit_q && fend == EXT_W'(hb_q) && idx_q != '0 &&
                       pend == EXT_W'(addr_q)) begin
            wr1_q     <= 1'b1;
            w1_idx_q  <= CNT_W'(idx_q - CNT_W'(1));
            w1_data_q <= {pb_q, LEN_W'(pl_q + len_q + hl_q)};
            shift_q   <= 1'b1;
            dn_q      <= 1'b1;
            sp_q      <= idx_q;
            dec_q     <= 1'b1;
          end else if (idx_q != '0 && pend == EXT_W'(addr_q)) begin
            wr1_q     <= 1'b1;
            w1_idx_q  <= CNT_W'(idx_q - CNT_W'(1));
            w1_data_q <= {pb_q, LEN_W'(pl_q + len_q)};
          end else if (hit_q && fend == EXT_W'(hb_q)) begin
            wr1_q     <= 1'b1;
            w1_idx_q  <= idx_q;
            w1_data_q <= {addr_q, LEN_W'(hl_q + len_q)};
          end else if (full) begin
            stat_q <= ST_FULL;
          end else begin
            shift_q    <= 1'b1;
            dn_q       <= 1'b0;
            sp_q       <= cnt_q;
            lim_q      <= idx_q;
            ins_q      <= 1'b1;
            ins_idx_q  <= idx_q;
            ins_data_q <= {addr_q, len_q};
            inc_q      <= 1'b1;
          end
        end
      end
      CMD_SHF_WR: begin
        sp_q <= sp_nxt;
      end
      CMD_DONE: begin
        res_st_q    <= stat_q;
        res_grant_q <= (is_alloc && stat_q == ST_OK) ? grant_q : '0;
        res_total_q <= (op_q == OP_QUERY) ? sum_q : '0;
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o    = res_vld_q;
  assign status_o          = res_st_q;
  assign granted_address_o = res_grant_q;
  assign total_free_o      = res_total_q;

endmodule

/* rtl/first_fit_segment_allocator.sv */
// First-fit segment allocator top level: sequencer plus datapath
// A request is taken when start is high and busy is low; its single result
// appears for one cycle with result_valid_o and cannot be held off. An
// operation reads and evaluates the table entries one at a time, then
// decides and, where needed, writes the updated entry, shifts entries (a
// read and a write each) and inserts one before it finishes. A scan that
// stops at an entry leaves the rest of the table to the shift; the table
// holds up to 64 entries. A rejected length goes straight to the finish.
// The result appears in the same cycle busy drops. The scan and the entry
// shifting both pass through the one read port of the segment table memory. A new
// request may be issued in the same cycle its predecessor's result is shown.
module first_fit_segment_allocator import ffsa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        operation_i,
  input  logic [LEN_W-1:0]  length_i,
  input  logic [AL_W-1:0]   align_log2_i,
  input  logic [ADDR_W-1:0] release_address_i,
  output logic              result_valid_o,
  output logic [1:0]        status_o,
  output logic [ADDR_W-1:0] granted_address_o,
  output logic [LEN_W-1:0]  total_free_o
);

  cmd_e       cmd;
  dp_status_t dp_stat;

  ffsa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (dp_stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  ffsa_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (dp_stat),
    .operation_i       (operation_i),
    .length_i          (length_i),
    .align_log2_i      (align_log2_i),
    .release_address_i (release_address_i),
    .result_valid_o    (result_valid_o),
    .status_o          (status_o),
    .granted_address_o (granted_address_o),
    .total_free_o      (total_free_o)
  );

endmodule

/* rtl/ffsa_checker.sv */
// Port-level checks for the segment allocator, bound to the top level
`include "first_fit_segment_allocator_macros.svh"

module ffsa_checker import ffsa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input logic [1:0]        status_o,
  input logic [ADDR_W-1:0] granted_address_o,
  input logic [LEN_W-1:0]  total_free_o
);

  `FFSA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `FFSA_ASSERT_NEXT(a_single_pulse, clk_i, rst_ni, result_valid_o, !result_valid_o)
  `FFSA_ASSERT_IMPL(a_result_ends_busy, clk_i, rst_ni, $fell(busy), result_valid_o)
  `FFSA_ASSERT_IMPL(a_grant_zero, clk_i, rst_ni, result_valid_o && status_o != ST_OK, granted_address_o == '0)
  `FFSA_ASSERT_IMPL(a_total_ok, clk_i, rst_ni, result_valid_o && total_free_o != '0, status_o == ST_OK)

endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (.*);

/* tb/first_fit_segment_allocator_tb.sv */
// Self-checking testbench for the first-fit segment allocator
`timescale 1ns / 100ps

module first_fit_segment_allocator_tb;
  import ffsa_pkg::*;

  typedef struct {
    status_e           st;
    logic [ADDR_W-1:0] grant;
    logic [LEN_W-1:0]  total;
  } answer_t;

  typedef struct {
    op_e               op;
    logic [LEN_W-1:0]  len;
    logic [AL_W-1:0]   al;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    answer_t           ans;
  } row_t;

  typedef struct {
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  len;
  } block_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        operation_i = OP_QUERY;
  logic [LEN_W-1:0]  length_i = '0;
  logic [AL_W-1:0]   align_log2_i = '0;
  logic [ADDR_W-1:0] release_address_i = '0;
  logic              result_valid_o;
  logic [1:0]        status_o;
  logic [ADDR_W-1:0] granted_address_o;
  logic [LEN_W-1:0]  total_free_o;

  // free-segment table as the block should hold it
  logic [ADDR_W-1:0] free_base[MAX_SEGMENTS];
  logic [LEN_W-1:0]  free_len[MAX_SEGMENTS];
  int unsigned       free_cnt;

  answer_t pending_answers[$];
  block_t  live_blocks[$];
  row_t    rows[$];
  int      mismatches;
  int      status_seen[4];
  int      idle_cycles;
  int      requests;

  localparam int WATCHDOG_LIMIT = 20000;

  first_fit_segment_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .length_i, .align_log2_i,
    .release_address_i, .result_valid_o, .status_o, .granted_address_o, .total_free_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void drop_entry(int unsigned pos);
    for (int unsigned j = pos; j + 1 < free_cnt; j++) begin
      free_base[j] = free_base[j+1];
      free_len[j]  = free_len[j+1];
    end
    free_cnt--;
  endfunction

  function automatic void add_entry(int unsigned pos, longint unsigned b, longint unsigned l);
    for (int unsigned j = free_cnt; j > pos; j--) begin
      free_base[j] = free_base[j-1];
      free_len[j]  = free_len[j-1];
    end
    free_base[pos] = b[ADDR_W-1:0];
    free_len[pos]  = l[LEN_W-1:0];
    free_cnt++;
  endfunction

  function automatic status_e carve(bit from_top, longint unsigned l, int unsigned al,
                                    output longint unsigned grant);
    longint unsigned align, pad, rest, b, p;
    int unsigned k, idx;
    bit found;
    align = 64'd1 << al;
    found = 0;
    k = 0;
    pad = 0;
    grant = 0;
    if (l == 0 || l > SPACE_SIZE) return ST_BADLEN;
    for (int unsigned i = 0; i < free_cnt; i++) begin
      idx = from_top ? free_cnt - 1 - i : i;
      b = free_base[idx];
      p = ((b + align - 1) & ~(align - 1)) - b;
      if (p + l <= free_len[idx]) begin
        k = idx;
        pad = p;
        found = 1;
        break;
      end
    end
    if (!found) return ST_NOFIT;
    rest = free_len[k] - l - pad;
    if (pad == 0) begin
      grant = free_base[k];
      if (rest > 0) begin
        free_base[k] = ADDR_W'(grant + l);
        free_len[k]  = LEN_W'(rest);
      end else begin
        drop_entry(k);
      end
    end else begin
      if (rest > 0 && free_cnt >= MAX_SEGMENTS) return ST_FULL;
      grant = free_base[k] + pad;
      free_len[k] = LEN_W'(pad);
      if (rest > 0) add_entry(k + 1, grant + l, rest);
    end
    grant = grant & ((64'd1 << ADDR_W) - 1);
    return ST_OK;
  endfunction

  function automatic status_e release_range(longint unsigned a, longint unsigned l);
    int unsigned pos;
    bit join_next, join_prev;
    pos = 0;
    if (l == 0 || l > SPACE_SIZE || a + l > SPACE_SIZE) return ST_BADLEN;
    while (pos < free_cnt && free_base[pos] < a) pos++;
    if (pos < free_cnt && a + l > free_base[pos]) return ST_BADLEN;
    if (pos > 0 && 64'(free_base[pos-1]) + free_len[pos-1] > a) return ST_BADLEN;
    join_next = pos < free_cnt && a + l == free_base[pos];
    join_prev = pos > 0 && 64'(free_base[pos-1]) + free_len[pos-1] == a;
    if (join_prev && join_next) begin
      free_len[pos-1] = LEN_W'(free_len[pos-1] + l + free_len[pos]);
      drop_entry(pos);
    end else if (join_prev) begin
      free_len[pos-1] = LEN_W'(free_len[pos-1] + l);
    end else if (join_next) begin
      free_base[pos] = ADDR_W'(a);
      free_len[pos]  = LEN_W'(free_len[pos] + l);
    end else begin
      if (free_cnt >= MAX_SEGMENTS) return ST_FULL;
      add_entry(pos, a, l);
    end
    return ST_OK;
  endfunction

  function automatic answer_t predict_answer(op_e op, logic [LEN_W-1:0] l,
                                             logic [AL_W-1:0] al, logic [ADDR_W-1:0] a);
    answer_t r;
    longint unsigned g, sum;
    g = 0;
    sum = 0;
    r.st = ST_OK;
    case (op)
      OP_ALLOC_FIRST, OP_ALLOC_LAST: begin
        r.st = carve(op == OP_ALLOC_LAST, l, al, g);
        if (r.st != ST_OK) g = 0;
      end
      OP_FREE: begin
        r.st = release_range(a, l);
      end
      default: begin
        for (int unsigned i = 0; i < free_cnt; i++) sum += free_len[i];
      end
    endcase
    r.grant = ADDR_W'(g);
    r.total = LEN_W'(sum);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned d;
    d = $urandom_range(0, 99);
    if (d < 55) return 0;
    if (d < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue(row_t r, int unsigned gap);
    answer_t pred;
    pred = predict_answer(r.op, r.len, r.al, r.addr);
    if ((r.op == OP_ALLOC_FIRST || r.op == OP_ALLOC_LAST) && pred.st == ST_OK)
      live_blocks.push_back('{pred.grant, r.len});
    pending_answers.push_back(r.typed ? r.ans : pred);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    operation_i       <= r.op;
    length_i          <= r.len;
    align_log2_i      <= r.al;
    release_address_i <= r.addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests++;
  endtask

  task automatic send(op_e op, logic [LEN_W-1:0] l, logic [AL_W-1:0] al,
                      logic [ADDR_W-1:0] a, int unsigned gap);
    row_t r;
    r.op = op; r.len = l; r.al = al; r.addr = a; r.typed = 0;
    r.ans = '{ST_OK, '0, '0};
    issue(r, gap);
  endtask

  task automatic free_live(int unsigned idx, int unsigned gap);
    block_t blk;
    blk = live_blocks[idx];
    live_blocks.delete(idx);
    send(OP_FREE, blk.len, AL_W'($urandom), blk.base, gap);
  endtask

  function automatic void row(op_e op, logic [LEN_W-1:0] l, logic [AL_W-1:0] al,
                              logic [ADDR_W-1:0] a, bit typed, status_e st,
                              logic [ADDR_W-1:0] g, logic [LEN_W-1:0] t);
    rows.push_back('{op, l, al, a, typed, '{st, g, t}});
  endfunction

  task automatic random_request();
    int unsigned d;
    logic [LEN_W-1:0] l;
    d = $urandom_range(0, 99);
    if (d < 40) begin
      l = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(1, 1 << 20))
                                      : LEN_W'($urandom_range(1, 64));
      send($urandom_range(0, 1) ? OP_ALLOC_LAST : OP_ALLOC_FIRST, l,
           ($urandom_range(0, 9) == 0) ? AL_W'($urandom) : AL_W'($urandom_range(0, 6)),
           ADDR_W'($urandom), pick_gap());
    end else if (d < 75 && live_blocks.size() > 0) begin
      free_live($urandom_range(0, live_blocks.size() - 1), pick_gap());
    end else if (d < 85) begin
      send(OP_QUERY, LEN_W'($urandom), AL_W'($urandom), ADDR_W'($urandom), pick_gap());
    end else begin
      send(op_e'($urandom_range(0, 3)), LEN_W'($urandom), AL_W'($urandom),
           ADDR_W'($urandom), pick_gap());
    end
  endtask

  task automatic fragment_burst();
    block_t grabbed[$];
    int unsigned n0;
    n0 = live_blocks.size();
    for (int i = 0; i < 140; i++) send(OP_ALLOC_FIRST, 2, 0, ADDR_W'($urandom), pick_gap());
    for (int unsigned i = n0; i < live_blocks.size(); i++) grabbed.push_back(live_blocks[i]);
    while (live_blocks.size() > n0) void'(live_blocks.pop_back());
    foreach (grabbed[i]) begin
      if (i % 2 == 0)
        send(OP_FREE, grabbed[i].len, AL_W'($urandom), grabbed[i].base, pick_gap());
      else live_blocks.push_back(grabbed[i]);
    end
  endtask

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", status_o);
      end else begin
        e = pending_answers.pop_front();
        status_seen[status_o]++;
        if (status_o !== e.st || granted_address_o !== e.grant || total_free_o !== e.total) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d grant %h total %h, got %0d %h %h",
                     e.st, e.grant, e.total, status_o, granted_address_o, total_free_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("first_fit_segment_allocator verification failed");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    requests = 0;
    idle_cycles = 0;
    free_cnt = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    row(OP_QUERY, '1, '1, '1, 1, ST_OK, '0, '0);
    row(OP_ALLOC_FIRST, 1, 0, 0, 1, ST_NOFIT, '0, '0);
    row(OP_FREE, 0, 0, 0, 1, ST_BADLEN, '0, '0);
    row(OP_ALLOC_LAST, 0, 0, 0, 1, ST_BADLEN, '0, '0);
    row(OP_FREE, SPACE_SIZE + 1, 0, 0, 1, ST_BADLEN, '0, '0);
    row(OP_FREE, 2, 0, '1, 1, ST_BADLEN, '0, '0);
    row(OP_FREE, SPACE_SIZE, 0, 0, 1, ST_OK, '0, '0);
    row(OP_QUERY, 0, 0, 0, 1, ST_OK, '0, SPACE_SIZE);
    row(OP_FREE, 1, 0, 24'h000100, 1, ST_BADLEN, '0, '0);
    row(OP_ALLOC_FIRST, SPACE_SIZE, 0, '1, 1, ST_OK, '0, '0);
    row(OP_QUERY, 0, 0, 0, 1, ST_OK, '0, '0);
    row(OP_FREE, SPACE_SIZE, 0, 0, 1, ST_OK, '0, '0);
    row(OP_ALLOC_FIRST, 16, 4, 0, 1, ST_OK, '0, '0);
    row(OP_ALLOC_LAST, 16, 31, 0, 0, ST_OK, '0, '0);
    row(OP_ALLOC_FIRST, 100, 20, 0, 0, ST_OK, '0, '0);
    row(OP_ALLOC_LAST, 100, 3, 0, 0, ST_OK, '0, '0);
    row(OP_ALLOC_FIRST, 5, 5, 0, 0, ST_OK, '0, '0);
    row(OP_ALLOC_LAST, SPACE_SIZE, 0, 0, 0, ST_OK, '0, '0);
    row(OP_QUERY, 0, 0, 0, 0, ST_OK, '0, '0);
    row(OP_FREE, 16, 0, 0, 0, ST_OK, '0, '0);
    row(OP_FREE, 16, 0, 0, 0, ST_OK, '0, '0);
    row(OP_FREE, 8, 0, 24'hFFFFF8, 0, ST_OK, '0, '0);
    row(OP_QUERY, 0, 0, 0, 0, ST_OK, '0, '0);
    foreach (rows[i]) issue(rows[i], 0);
    live_blocks.delete();

    for (int i = 0; i < 110; i++) random_request();
    fragment_burst();
    for (int i = 0; i < 110; i++) random_request();
    fragment_burst();
    for (int i = 0; i < 80; i++) random_request();
    start <= 1'b0;

    while (pending_answers.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);

    $display("requests issued: %0d; status ok %0d, no fit %0d, table full %0d, bad length %0d",
             requests, status_seen[ST_OK], status_seen[ST_NOFIT], status_seen[ST_FULL],
             status_seen[ST_BADLEN]);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("first_fit_segment_allocator verification clean");
    end else begin
      $display("first_fit_segment_allocator verification failed");
    end
    $finish;
  end

endmodule
